[rtl/ambient_light_display_dimmer_core_macros.svh]
// ----------------------------------------------------------------------------
// Ambient light dimmer assertion macros
// Shorthand for the clocked concurrent assertions used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AMBIENT_LIGHT_DISPLAY_DIMMER_CORE_MACROS_SVH
`define AMBIENT_LIGHT_DISPLAY_DIMMER_CORE_MACROS_SVH

// assertion sampled on the rising clock edge, switched off during reset
`define ALD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on the rising clock edge, active during reset as well
`define ALD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ald_pkg.sv]
// ----------------------------------------------------------------------------
// Ambient light dimmer package
// Shared constants and register index codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ald_pkg;

   localparam int BRIGHT_W       = 8;
   localparam int RSP_W          = 16;
   localparam int CSR_ADDR_W     = 3;

   localparam int BRIGHT_LIMIT   = 5000;
   localparam int OLED_ON_MARGIN = 10;
   localparam int BLANK_MARGIN   = 3;

   // register reset values
   localparam int OLED_OFF_THR_RST  = 10;
   localparam int LED_DIS_THR_RST   = 5;
   localparam int LED_DIM_THR_RST   = 20;
   localparam int LED_MAP_MAX_RST   = 500;
   localparam int LED_MIN_RST       = 1;
   localparam int LED_MAX_DAY_RST   = 15;
   localparam int LED_MAX_NIGHT_RST = 5;
   localparam int LED_HYST_RST      = 1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_OLED_OFF_THR  = 3'd0,
      CSR_LED_DIS_THR   = 3'd1,
      CSR_LED_DIM_THR   = 3'd2,
      CSR_LED_MAP_MAX   = 3'd3,
      CSR_LED_MIN       = 3'd4,
      CSR_LED_MAX_DAY   = 3'd5,
      CSR_LED_MAX_NIGHT = 3'd6,
      CSR_LED_HYST      = 3'd7
   } csr_index_type;

endpackage

`default_nettype wire

[rtl/ald_div.sv]
// ----------------------------------------------------------------------------
// Ambient light dimmer serial divider
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
`default_nettype none

module ald_div #(
   parameter int NUM_W = 25,
   parameter int DEN_W = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] dividend,
   input  wire logic [DEN_W-1:0] divisor,
   output logic                  done,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   // shift in the next dividend bit and try a subtraction
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/ambient_light_display_dimmer_core.sv]
// Ambient light display dimmer. One light reading is taken per transaction and
// yields one result: the OLED off decision with its 10 lux hysteresis, and the
// LED blank/brightness decision for readings under 5000 lux. A reading that
// needs the linear brightness map is accepted, goes through a registered
// multiply and a launch state, then the one-bit-per-clock restoring divider and
// its registered done flag, and then waits until the output register is free
// to clamp, apply the hysteresis step and load the result register. Other
// readings go from acceptance straight to that last step. A new reading is
// accepted while a finished result still waits in the output register.
// Configuration writes take effect at once and belong only to idle periods.
// ----------------------------------------------------------------------------
// Ambient light display dimmer core
// Top level: handshake, state, configuration registers and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_display_dimmer_core #(
   parameter int LUX_BITS = 17,
   localparam int REQ_W = ((LUX_BITS + 3 + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // req: light_level, is_day, is_night, no_presence (from bit 0)
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [REQ_W-1:0]              req_tdata,
   // rsp: oled_off, led_updated, led_on, led_brightness (from bit 0)
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [ald_pkg::RSP_W-1:0]          rsp_tdata,
   input  wire logic                          csr_we,
   input  wire logic [ald_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [LUX_BITS-1:0]           csr_wdata
);

   import ald_pkg::*;

   localparam int PROD_W = LUX_BITS + BRIGHT_W;
   localparam int CMP_W  = ((LUX_BITS > 13) ? LUX_BITS : 13) + 1;
   localparam int PAD_W  = RSP_W - 3 - BRIGHT_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_LAUNCH,
      S_DIV,
      S_FIN
   } state_type;

   // configuration registers
   logic [LUX_BITS-1:0] oled_thr_ff;
   logic [LUX_BITS-1:0] dis_thr_ff;
   logic [LUX_BITS-1:0] dim_thr_ff;
   logic [LUX_BITS-1:0] map_max_ff;
   logic [BRIGHT_W-1:0] min_ff;
   logic [BRIGHT_W-1:0] max_day_ff;
   logic [BRIGHT_W-1:0] max_night_ff;
   logic [BRIGHT_W-1:0] hyst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         oled_thr_ff  <= LUX_BITS'(OLED_OFF_THR_RST);
         dis_thr_ff   <= LUX_BITS'(LED_DIS_THR_RST);
         dim_thr_ff   <= LUX_BITS'(LED_DIM_THR_RST);
         map_max_ff   <= LUX_BITS'(LED_MAP_MAX_RST);
         min_ff       <= BRIGHT_W'(LED_MIN_RST);
         max_day_ff   <= BRIGHT_W'(LED_MAX_DAY_RST);
         max_night_ff <= BRIGHT_W'(LED_MAX_NIGHT_RST);
         hyst_ff      <= BRIGHT_W'(LED_HYST_RST);
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_OLED_OFF_THR:  oled_thr_ff  <= csr_wdata;
            CSR_LED_DIS_THR:   dis_thr_ff   <= csr_wdata;
            CSR_LED_DIM_THR:   dim_thr_ff   <= csr_wdata;
            CSR_LED_MAP_MAX:   map_max_ff   <= csr_wdata;
            CSR_LED_MIN:       min_ff       <= csr_wdata[BRIGHT_W-1:0];
            CSR_LED_MAX_DAY:   max_day_ff   <= csr_wdata[BRIGHT_W-1:0];
            CSR_LED_MAX_NIGHT: max_night_ff <= csr_wdata[BRIGHT_W-1:0];
            CSR_LED_HYST:      hyst_ff      <= csr_wdata[BRIGHT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer and dimmer state
   state_type           state_ff, state_in;
   logic                oled_off_ff, oled_off_in;
   logic                blanked_ff, blanked_in;
   logic [BRIGHT_W-1:0] last_ff, last_in;
   logic                on_held_ff, on_held_in;
   logic [BRIGHT_W-1:0] int_held_ff, int_held_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                map_ff, map_in;
   logic                span_pos_ff, span_pos_in;
   logic                absent_ff, absent_in;
   logic                upd_ff, upd_in;
   logic [BRIGHT_W-1:0] hi_ff, hi_in;
   logic [LUX_BITS-1:0] diff_ff, diff_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   logic [LUX_BITS-1:0] lux;
   logic                is_day, is_night, no_presence;
   logic                accept;
   logic                bright_ok;
   logic                oled_next, blank_next;
   logic                hi_lt_lo;
   logic [BRIGHT_W-1:0] mag;
   logic [BRIGHT_W-1:0] nb;
   logic [BRIGHT_W:0]   last_up, nb_up;
   logic                move;
   logic                out_free;
   logic                div_done;
   logic [PROD_W-1:0]   quo;

   assign lux         = req_tdata[LUX_BITS-1:0];
   assign is_day      = req_tdata[LUX_BITS];
   assign is_night    = req_tdata[LUX_BITS+1];
   assign no_presence = req_tdata[LUX_BITS+2];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign bright_ok = CMP_W'(lux) < CMP_W'(BRIGHT_LIMIT);

   // OLED hysteresis: off below threshold, on again at threshold plus margin
   always_comb begin
      oled_next = oled_off_ff;
      if (oled_off_ff &&
          ({1'b0, lux} >= ({1'b0, oled_thr_ff} + (LUX_BITS+1)'(OLED_ON_MARGIN))))
         oled_next = 1'b0;
      else if (!oled_off_ff && (lux < oled_thr_ff))
         oled_next = 1'b1;
   end

   // LED blank band; lux + 3 <= thr also covers a threshold under the margin
   always_comb begin
      blank_next = blanked_ff;
      if (bright_ok) begin
         if (blanked_ff) begin
            if ({1'b0, lux} > ({1'b0, dis_thr_ff} + (LUX_BITS+1)'(BLANK_MARGIN)))
               blank_next = 1'b0;
         end else if (is_night &&
                      (({1'b0, lux} + (LUX_BITS+1)'(BLANK_MARGIN)) <= {1'b0, dis_thr_ff})) begin
            blank_next = 1'b1;
         end
      end
   end

   // brightness selection once the quotient is known
   assign hi_lt_lo = hi_ff < min_ff;
   assign mag      = hi_lt_lo ? (min_ff - hi_ff) : (hi_ff - min_ff);

   always_comb begin
      if (!span_pos_ff)
         nb = hi_lt_lo ? min_ff : hi_ff;
      else if (hi_lt_lo)
         nb = (quo != '0) ? min_ff : hi_ff;
      else if (quo > PROD_W'(hi_ff - min_ff))
         nb = hi_ff;
      else
         nb = min_ff + quo[BRIGHT_W-1:0];
   end

   assign last_up = {1'b0, last_ff} + {1'b0, hyst_ff};
   assign nb_up   = {1'b0, nb} + {1'b0, hyst_ff};
   assign move    = ({1'b0, nb} > last_up) || (nb_up < {1'b0, last_ff});

   always_comb begin
      state_in     = state_ff;
      oled_off_in  = oled_off_ff;
      blanked_in   = blanked_ff;
      last_in      = last_ff;
      on_held_in   = on_held_ff;
      int_held_in  = int_held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      map_in       = map_ff;
      span_pos_in  = span_pos_ff;
      absent_in    = absent_ff;
      upd_in       = upd_ff;
      hi_in        = hi_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               oled_off_in = oled_next;
               blanked_in  = blank_next;
               absent_in   = no_presence;
               upd_in      = bright_ok;
               hi_in       = is_day ? max_day_ff : max_night_ff;
               diff_in     = lux - dim_thr_ff;
               span_pos_in = map_max_ff > dim_thr_ff;
               map_in      = bright_ok && !blank_next && (lux > dim_thr_ff);
               if (bright_ok) begin
                  if (blank_next) begin
                     on_held_in = 1'b0;
                  end else begin
                     on_held_in = 1'b1;
                     if (lux <= dim_thr_ff)
                        int_held_in = '0;
                  end
               end
               if (bright_ok && !blank_next && (lux > dim_thr_ff) &&
                   (map_max_ff > dim_thr_ff))
                  state_in = S_MUL;
               else
                  state_in = S_FIN;
            end
         end
         S_MUL: begin
            prod_in  = PROD_W'(diff_ff) * PROD_W'(mag);
            state_in = S_LAUNCH;
         end
         S_LAUNCH: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done)
               state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               if (map_ff) begin
                  if (move) begin
                     last_in     = nb;
                     int_held_in = nb;
                  end else begin
                     int_held_in = last_ff;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {PAD_W'(0),
                               (on_held_ff ? (map_ff ? (move ? nb : last_ff) : int_held_ff)
                                           : BRIGHT_W'(0)),
                               on_held_ff, upd_ff, (oled_off_ff || absent_ff)};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oled_off_ff  <= 1'b0;
         blanked_ff   <= 1'b0;
         last_ff      <= BRIGHT_W'(LED_MIN_RST);
         on_held_ff   <= 1'b1;
         int_held_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         map_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oled_off_ff  <= oled_off_in;
         blanked_ff   <= blanked_in;
         last_ff      <= last_in;
         on_held_ff   <= on_held_in;
         int_held_ff  <= int_held_in;
         rsp_valid_ff <= rsp_valid_in;
         map_ff       <= map_in;
      end
      rsp_data_ff <= rsp_data_in;
      span_pos_ff <= span_pos_in;
      absent_ff   <= absent_in;
      upd_ff      <= upd_in;
      hi_ff       <= hi_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
   end

   ald_div #(
      .NUM_W(PROD_W),
      .DEN_W(LUX_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == S_LAUNCH),
      .dividend(prod_ff),
      .divisor (map_max_ff - dim_thr_ff),
      .done    (div_done),
      .quotient(quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/ald_checker.sv]
// ----------------------------------------------------------------------------
// Ambient light dimmer port checker
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ambient_light_display_dimmer_core_macros.svh"

module ald_checker #(
   parameter int LUX_BITS = 17,
   localparam int REQ_W = ((LUX_BITS + 3 + 7) / 8) * 8
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [REQ_W-1:0]               req_tdata,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [ald_pkg::RSP_W-1:0]      rsp_tdata,
   input wire logic                           csr_we,
   input wire logic [ald_pkg::CSR_ADDR_W-1:0] csr_addr,
   input wire logic [LUX_BITS-1:0]            csr_wdata
);

   import ald_pkg::*;

   logic req_fire;
   logic rsp_stall;

   assign req_fire  = req_tvalid && req_tready;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `ALD_ASSERT_ALWAYS(a_rst_no_rsp, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `ALD_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata),
      "stalled result changed")
   `ALD_ASSERT(a_busy_after_req, clock, reset, req_fire |=> !req_tready,
      "new reading taken in the cycle after a transaction")
   `ALD_ASSERT(a_blank_dark, clock, reset,
      (rsp_tvalid && !rsp_tdata[2]) |-> (rsp_tdata[10:3] == '0),
      "brightness nonzero while LED is blanked")
   // register writes only while the core is idle with no result pending
   `ALD_ASSERT(a_cfg_idle, clock, reset,
      csr_we |-> (req_tready && !rsp_tvalid && !$isunknown(csr_addr) && !$isunknown(csr_wdata)),
      "register written while a transaction is in flight")

endmodule

bind ambient_light_display_dimmer_core ald_checker #(
   .LUX_BITS(LUX_BITS)
) u_ald_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata (req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .csr_we    (csr_we),
   .csr_addr  (csr_addr),
   .csr_wdata (csr_wdata)
);

`default_nettype wire
